@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ src/sabs_pkg.sv @@
// ----------------------------------------------------------------------------
// sabs_pkg
// Sizes, opcodes and controller/datapath interface types of the search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sabs_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned SRCH_W = CNT_W + 1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_init;
    logic scan;
    logic wr_m;
    logic wr_i;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pass_more;
    logic scan_done;
    logic cnt_zero;
    logic srch_more;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ src/sabs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sabs_ctrl
// Sequencer for load, selection sort passes, binary search and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sabs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             opcode_i,
  input  wire logic             last_i,
  output logic                  in_stall_o,
  output sabs_pkg::cmd_t        cmd_o,
  input  wire sabs_pkg::status_t status_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PASS   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_WR_M   = 8'b0000_1000,
    S_WR_I   = 8'b0001_0000,
    S_SR_RD  = 8'b0010_0000,
    S_SR_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == sabs_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
            if (last_i) begin
              cmd_o.sort_init = 1'b1;
              state_d         = S_PASS;
            end
          end else begin
            cmd_o.srch_init = 1'b1;
            state_d         = status_i.cnt_zero ? S_DONE : S_SR_RD;
          end
        end
      end
      S_PASS: begin
        if (status_i.pass_more) begin
          cmd_o.pass_init = 1'b1;
          state_d         = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_WR_M;
        end
      end
      S_WR_M: begin
        cmd_o.wr_m = 1'b1;
        state_d    = S_WR_I;
      end
      S_WR_I: begin
        cmd_o.wr_i = 1'b1;
        state_d    = S_PASS;
      end
      S_SR_RD: begin
        cmd_o.srch_rd = 1'b1;
        state_d       = S_SR_CMP;
      end
      S_SR_CMP: begin
        cmd_o.srch_step = 1'b1;
        state_d         = status_i.srch_more ? S_SR_RD : S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NXT(a_last_load_sorts, accept && (opcode_i == sabs_pkg::OP_LOAD) && last_i, state_q == S_PASS)
  `ASSERT_IMP(a_out_load_free, cmd_o.out_load, status_i.out_free)
  `ASSERT_NXT(a_search_holds_input, accept && (opcode_i == sabs_pkg::OP_SEARCH), in_stall_o)

endmodule

`default_nettype wire

@@ src/sabs_dp.sv @@
// ----------------------------------------------------------------------------
// sabs_dp
// Element store, sort scan registers, search bounds and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sabs_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sabs_pkg::cmd_t                cmd_i,
  output sabs_pkg::status_t                  status_o,
  input  wire logic [sabs_pkg::DATA_W-1:0]   value_i,
  input  wire logic                          last_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic                               found_o,
  output logic [sabs_pkg::POS_W-1:0]         position_o
);

  localparam int unsigned AW = sabs_pkg::ADDR_W;
  localparam int unsigned CW = sabs_pkg::CNT_W;
  localparam int unsigned DW = sabs_pkg::DATA_W;
  localparam int unsigned SW = sabs_pkg::SRCH_W;
  localparam logic [CW-1:0] DepthC = CW'(sabs_pkg::DEPTH);

  logic [DW-1:0] mem [sabs_pkg::DEPTH];

  logic [CW-1:0]        count_q;
  logic                 closed_q;
  logic [AW-1:0]        i_q;
  logic [CW-1:0]        j_q;
  logic                 first_q;
  logic signed [DW-1:0] min_val_q;
  logic [AW-1:0]        min_idx_q;
  logic [DW-1:0]        ival_q;
  logic signed [DW-1:0] rd_data_q;
  logic [AW-1:0]        rd_idx_q;
  logic                 rd_vld_q;
  logic signed [DW-1:0] key_q;
  logic signed [SW-1:0] lo_q, hi_q;
  logic [AW-1:0]        mid_q;
  logic                 hit_q;
  logic                 out_vld_q;
  logic                 found_q;
  logic [sabs_pkg::POS_W-1:0] pos_q;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [DW-1:0]        wdata;
  logic [AW-1:0]        raddr;
  logic                 issue;
  logic signed [SW-1:0] mid_sum;
  logic [AW-1:0]        mid_new;
  logic signed [SW-1:0] mid_s;
  logic                 e_le, e_ge;
  logic signed [SW-1:0] lo_n, hi_n;

  assign issue   = cmd_i.scan && (j_q < count_q);
  assign mid_sum = (lo_q + hi_q) >>> 1;
  assign mid_new = mid_sum[AW-1:0];
  assign raddr   = cmd_i.srch_rd ? mid_new : j_q[AW-1:0];

  assign mid_s = $signed(SW'(mid_q));
  assign e_le  = rd_data_q <= key_q;
  assign e_ge  = rd_data_q >= key_q;
  assign lo_n  = e_le ? (mid_s + SW'(1)) : lo_q;
  assign hi_n  = e_ge ? (mid_s - SW'(1)) : hi_q;

  always_comb begin
    we    = 1'b0;
    waddr = i_q;
    wdata = min_val_q;
    if (cmd_i.load) begin
      we    = closed_q || (count_q < DepthC);
      waddr = closed_q ? '0 : count_q[AW-1:0];
      wdata = value_i;
    end else if (cmd_i.wr_m) begin
      we    = 1'b1;
      waddr = min_idx_q;
      wdata = ival_q;
    end else if (cmd_i.wr_i) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[raddr];
  end

  assign status_o.pass_more = (CW'(i_q) + CW'(1)) < count_q;
  assign status_o.scan_done = (j_q >= count_q) && !rd_vld_q;
  assign status_o.cnt_zero  = (count_q == '0);
  assign status_o.srch_more = lo_n <= hi_n;
  assign status_o.out_free  = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      closed_q  <= 1'b1;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (closed_q) begin
          count_q <= CW'(1);
        end else if (count_q < DepthC) begin
          count_q <= count_q + CW'(1);
        end
        closed_q <= last_i;
      end
      rd_vld_q <= issue;
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= j_q[AW-1:0];
    if (cmd_i.sort_init) begin
      i_q <= '0;
    end else if (cmd_i.wr_i) begin
      i_q <= i_q + AW'(1);
    end
    if (cmd_i.pass_init) begin
      j_q     <= CW'(i_q);
      first_q <= 1'b1;
    end else if (issue) begin
      j_q <= j_q + CW'(1);
    end
    if (rd_vld_q) begin
      if (first_q) begin
        first_q   <= 1'b0;
        min_val_q <= rd_data_q;
        min_idx_q <= rd_idx_q;
        ival_q    <= rd_data_q;
      end else if (min_val_q > rd_data_q) begin
        min_val_q <= rd_data_q;
        min_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.srch_init) begin
      key_q <= value_i;
      lo_q  <= '0;
      hi_q  <= $signed(SW'(count_q)) - SW'(1);
      mid_q <= '0;
      hit_q <= 1'b0;
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid_new;
    end
    if (cmd_i.srch_step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      hit_q <= e_le && e_ge;
    end
    if (cmd_i.out_load) begin
      found_q <= hit_q;
      pos_q   <= sabs_pkg::POS_W'(mid_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

`include "assert_macros.svh"

  `ASSERT_IMP(a_count_bound, 1'b1, count_q <= DepthC)
  `ASSERT_IMP(a_scan_in_range, rd_vld_q, CW'(rd_idx_q) < count_q)
  `ASSERT_IMP(a_no_write_in_scan, cmd_i.scan, !we)

endmodule

`default_nettype wire

@@ src/sorted_array_binary_search_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_array_binary_search_unit
// Loads signed elements, sorts a closed set, answers binary search queries.
// ----------------------------------------------------------------------------
// Load items that are not marked last leave in_stall_o low. A load marked last
// closes the set and starts a selection sort over the element store (one write
// port, one read port), which reads one element per cycle. Each pass scans the
// unsorted tail for its minimum and then swaps it into place; in_stall_o is
// high throughout the sort. A search runs its probes one after another, each a
// store read and then a compare, and may then wait for the result register to
// drain. One item is in work at a time; a finished result waits in the output
// register while new items enter. An empty set answers found 0, position 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_binary_search_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        opcode_i,
  input  wire logic signed [sabs_pkg::DATA_W-1:0] value_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             found_o,
  output logic [sabs_pkg::POS_W-1:0]       position_o
);

  sabs_pkg::cmd_t    cmd;
  sabs_pkg::status_t status;

  sabs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  sabs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .found_o     (found_o),
    .position_o  (position_o)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_array_binary_search_unit. Items go in through
// a shared send task, which also advances a local model of the element store
// (append, selection sort on a closed set, binary search). Expected answers
// queue up in order. A checker process compares each result that leaves the
// block against the oldest expected answer. Tests cover the empty store, the
// value extremes, searches while a set is still open, a store driven past
// full, and a long random run with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sabs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TARGET_ITEMS = 1050;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam logic signed [DATA_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     opcode_i    = OP_LOAD;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     last_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     found_o;
  logic [POS_W-1:0]         position_o;

  logic signed [DATA_W-1:0] elems [DEPTH];
  int unsigned              elem_count  = 0;
  bit                       set_sealed  = 1'b1;
  answer_t                  pending_answers [$];
  answer_t                  want;
  int unsigned              items_sent  = 0;
  int unsigned              answers_seen = 0;
  int unsigned              mismatches  = 0;
  int unsigned              stall_run   = 0;
  bit                       quiet       = 1'b0;

  sorted_array_binary_search_unit dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run   <= pick_gap();
    end
  end

  function automatic void sort_elems();
    int unsigned m;
    logic signed [DATA_W-1:0] t;
    for (int unsigned i = 0; i < elem_count; i++) begin
      m = i;
      for (int unsigned j = i + 1; j < elem_count; j++)
        if (elems[m] > elems[j]) m = j;
      t        = elems[i];
      elems[i] = elems[m];
      elems[m] = t;
    end
  endfunction

  function automatic answer_t lookup(logic signed [DATA_W-1:0] key);
    answer_t a;
    int lo, hi, k;
    a = '0;
    if (elem_count == 0) return a;
    lo = 0;
    hi = int'(elem_count) - 1;
    k  = 0;
    do begin
      k = (lo + hi) / 2;
      if (elems[k] <= key) lo = k + 1;
      if (elems[k] >= key) hi = k - 1;
    end while (lo <= hi);
    a.found    = (elems[k] == key);
    a.position = POS_W'(k);
    return a;
  endfunction

  function automatic void track_item(opcode_e op, logic signed [DATA_W-1:0] v, logic lst);
    if (op == OP_SEARCH) begin
      pending_answers.push_back(lookup(v));
      return;
    end
    if (set_sealed) begin
      elem_count = 0;
      set_sealed = 1'b0;
    end
    if (elem_count < DEPTH) begin
      elems[elem_count] = v;
      elem_count++;
    end
    if (lst) begin
      sort_elems();
      set_sealed = 1'b1;
    end
  endfunction

  task automatic send_item(opcode_e op, logic signed [DATA_W-1:0] v, logic lst);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= v;
    last_i     <= lst;
    do @(posedge clk_i); while (in_stall_o);
    track_item(op, v, lst);
    items_sent++;
  endtask

  task automatic load_elem(logic signed [DATA_W-1:0] v, logic lst);
    send_item(OP_LOAD, v, lst);
  endtask

  task automatic search_key(logic signed [DATA_W-1:0] key);
    send_item(OP_SEARCH, key, 1'($urandom_range(0, 1)));
  endtask

  task automatic hold_until_answered();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return int'($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 5))
          0: return ELEM_MIN;
          1: return ELEM_MIN + 1;
          2: return ELEM_MAX;
          3: return ELEM_MAX - 1;
          4: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    logic signed [DATA_W-1:0] e;
    int unsigned r;
    r = $urandom_range(0, 9);
    e = (elem_count != 0) ? elems[$urandom_range(0, elem_count - 1)] : '0;
    case (r)
      0, 1, 2, 3, 4: return e;
      5: return e + 1;
      6: return e - 1;
      7: return $urandom;
      8: return ELEM_MIN;
      default: return ELEM_MAX;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d unexpected: found=%0b position=%0d",
                   answers_seen, found_o, position_o);
      end else begin
        want = pending_answers.pop_front();
        if (found_o !== want.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d found: expected %0b, got %0b",
                     answers_seen, want.found, found_o);
        end
        if (position_o !== want.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d position: expected %0d, got %0d",
                     answers_seen, want.position, position_o);
        end
      end
    end
  end

  task automatic test_empty_store();
    search_key(0);
    search_key(ELEM_MIN);
    search_key(ELEM_MAX);
  endtask

  task automatic test_extremes();
    load_elem(ELEM_MAX, 1'b0);
    load_elem(ELEM_MIN, 1'b0);
    load_elem(0, 1'b0);
    load_elem(-1, 1'b0);
    load_elem(1, 1'b0);
    load_elem(0, 1'b0);
    load_elem(ELEM_MIN + 1, 1'b1);
    search_key(ELEM_MIN);
    search_key(ELEM_MAX);
    search_key(0);
    search_key(-1);
    search_key(2);
    search_key(ELEM_MIN + 1);
    search_key(ELEM_MAX - 1);
  endtask

  task automatic test_open_set();
    load_elem(5, 1'b0);
    load_elem(-5, 1'b0);
    search_key(5);
    search_key(-5);
    search_key(3);
    load_elem(7, 1'b0);
    search_key(7);
    load_elem(-9, 1'b1);
    search_key(7);
    search_key(-9);
  endtask

  task automatic test_full_store();
    for (int unsigned i = 0; i < DEPTH + 2; i++)
      load_elem(pick_value(0), i == DEPTH + 1);
    search_key(elems[0]);
    search_key(elems[DEPTH-1]);
    search_key(ELEM_MIN);
    search_key(ELEM_MAX);
    repeat (12) search_key(pick_key());
    hold_until_answered();
  endtask

  task automatic test_random();
    int unsigned kind, n, mode;
    while (items_sent < TARGET_ITEMS) begin
      kind  = $urandom_range(0, 9);
      mode  = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 5) == 0);
      if (kind < 7) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int unsigned i = 0; i < n; i++)
          load_elem(pick_value(mode), i == n - 1);
        repeat ($urandom_range(2, 8)) search_key(pick_key());
      end else if (kind == 7) begin
        n = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n; i++)
          load_elem(pick_value(mode), 1'b0);
        repeat ($urandom_range(1, 4)) search_key(pick_key());
        load_elem(pick_value(mode), 1'($urandom_range(0, 1)));
        search_key(pick_key());
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6))
          send_item(opcode_e'($urandom_range(0, 1)), pick_value(mode),
                    1'($urandom_range(0, 1)));
      end else begin
        hold_until_answered();
        repeat ($urandom_range(3, 10)) search_key(pick_key());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_extremes();
    test_open_set();
    hold_until_answered();
    test_full_store();
    test_random();
    hold_until_answered();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

endmodule
